// ----- hdl/md5_pkg.sv -----
// md5_pkg: shared types, constants and round tables for the md5 digest engine
// no dependencies; used by md5_ctrl, md5_dp and the top level

package md5_pkg;

    localparam logic [31:0] IV_A = 32'h67452301;
    localparam logic [31:0] IV_B = 32'hefcdab89;
    localparam logic [31:0] IV_C = 32'h98badcfe;
    localparam logic [31:0] IV_D = 32'h10325476;

    localparam logic [5:0]  ROUND_LAST = 6'd63;
    localparam logic [2:0]  POS_LAST   = 3'd7;
    localparam logic [31:0] PAD_WORD   = 32'h0000_0080;

    // controller to datapath
    typedef struct packed {
        logic       load_word;
        logic       init_work;
        logic       do_round;
        logic       fold;
        logic       pad;
        logic       clear_blk;
        logic       write_len;
        logic       restart;
        logic [5:0] round_idx;
    } md5_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [2:0] pos;
    } md5_stat_t;

    function automatic logic [31:0] round_const(input logic [5:0] i);
        logic [31:0] k;
        case (i)
            6'd0:  k = 32'd3614090360;
            6'd1:  k = 32'd3905402710;
            6'd2:  k = 32'd606105819;
            6'd3:  k = 32'd3250441966;
            6'd4:  k = 32'd4118548399;
            6'd5:  k = 32'd1200080426;
            6'd6:  k = 32'd2821735955;
            6'd7:  k = 32'd4249261313;
            6'd8:  k = 32'd1770035416;
            6'd9:  k = 32'd2336552879;
            6'd10: k = 32'd4294925233;
            6'd11: k = 32'd2304563134;
            6'd12: k = 32'd1804603682;
            6'd13: k = 32'd4254626195;
            6'd14: k = 32'd2792965006;
            6'd15: k = 32'd1236535329;
            6'd16: k = 32'd4129170786;
            6'd17: k = 32'd3225465664;
            6'd18: k = 32'd643717713;
            6'd19: k = 32'd3921069994;
            6'd20: k = 32'd3593408605;
            6'd21: k = 32'd38016083;
            6'd22: k = 32'd3634488961;
            6'd23: k = 32'd3889429448;
            6'd24: k = 32'd568446438;
            6'd25: k = 32'd3275163606;
            6'd26: k = 32'd4107603335;
            6'd27: k = 32'd1163531501;
            6'd28: k = 32'd2850285829;
            6'd29: k = 32'd4243563512;
            6'd30: k = 32'd1735328473;
            6'd31: k = 32'd2368359562;
            6'd32: k = 32'd4294588738;
            6'd33: k = 32'd2272392833;
            6'd34: k = 32'd1839030562;
            6'd35: k = 32'd4259657740;
            6'd36: k = 32'd2763975236;
            6'd37: k = 32'd1272893353;
            6'd38: k = 32'd4139469664;
            6'd39: k = 32'd3200236656;
            6'd40: k = 32'd681279174;
            6'd41: k = 32'd3936430074;
            6'd42: k = 32'd3572445317;
            6'd43: k = 32'd76029189;
            6'd44: k = 32'd3654602809;
            6'd45: k = 32'd3873151461;
            6'd46: k = 32'd530742520;
            6'd47: k = 32'd3299628645;
            6'd48: k = 32'd4096336452;
            6'd49: k = 32'd1126891415;
            6'd50: k = 32'd2878612391;
            6'd51: k = 32'd4237533241;
            6'd52: k = 32'd1700485571;
            6'd53: k = 32'd2399980690;
            6'd54: k = 32'd4293915773;
            6'd55: k = 32'd2240044497;
            6'd56: k = 32'd1873313359;
            6'd57: k = 32'd4264355552;
            6'd58: k = 32'd2734768916;
            6'd59: k = 32'd1309151649;
            6'd60: k = 32'd4149444226;
            6'd61: k = 32'd3174756917;
            6'd62: k = 32'd718787259;
            6'd63: k = 32'd3951481745;
            default: k = 32'd0;
        endcase
        return k;
    endfunction

    // shift amount picked by round group and round mod 4
    function automatic logic [4:0] rot_amount(input logic [3:0] sel);
        logic [4:0] s;
        case (sel)
            4'd0:  s = 5'd7;
            4'd1:  s = 5'd12;
            4'd2:  s = 5'd17;
            4'd3:  s = 5'd22;
            4'd4:  s = 5'd5;
            4'd5:  s = 5'd9;
            4'd6:  s = 5'd14;
            4'd7:  s = 5'd20;
            4'd8:  s = 5'd4;
            4'd9:  s = 5'd11;
            4'd10: s = 5'd16;
            4'd11: s = 5'd23;
            4'd12: s = 5'd6;
            4'd13: s = 5'd10;
            4'd14: s = 5'd15;
            4'd15: s = 5'd21;
            default: s = 5'd0;
        endcase
        return s;
    endfunction

endpackage

// ----- hdl/md5_in_if.sv -----
// md5_in_if: message word channel, valid/ready with payload
// no dependencies

interface md5_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] data_word;
    logic        word_present;
    logic        end_of_message;

    modport source (output valid, output data_word, output word_present,
                    output end_of_message, input ready);
    modport sink   (input valid, input data_word, input word_present,
                    input end_of_message, output ready);
endinterface

// ----- hdl/md5_out_if.sv -----
// md5_out_if: digest channel, valid/ready with four 32-bit digest words
// no dependencies

interface md5_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_a;
    logic [31:0] digest_b;
    logic [31:0] digest_c;
    logic [31:0] digest_d;

    modport source (output valid, output digest_a, output digest_b,
                    output digest_c, output digest_d, input ready);
    modport sink   (input valid, input digest_a, input digest_b,
                    input digest_c, input digest_d, output ready);
endinterface

// ----- hdl/md5_digest_engine.sv -----
// md5_digest_engine: streaming md5 over 64-bit little-endian message words
// a word that does not complete a block leaves the input ready; the eighth word of a block
// goes through intake, 64 rounds in the shared round unit and the chaining fold before the
// next transfer; end of message: padding and compression, a second compression when the
// length spills into an extra block, then the digest is held until its transfer
// reset (async, active low) loads the md5 initial value and clears the word counters

module md5_digest_engine (
    input  logic      clk,
    input  logic      rst_n,
    md5_in_if.sink    msg,
    md5_out_if.source digest
);

    md5_pkg::md5_cmd_t  cmd;
    md5_pkg::md5_stat_t stat;

    md5_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (msg.valid),
        .word_present   (msg.word_present),
        .end_of_message (msg.end_of_message),
        .in_ready       (msg.ready),
        .out_valid      (digest.valid),
        .out_ready      (digest.ready),
        .stat           (stat),
        .cmd            (cmd)
    );

    md5_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .data_word (msg.data_word),
        .stat      (stat),
        .digest_a  (digest.digest_a),
        .digest_b  (digest.digest_b),
        .digest_c  (digest.digest_c),
        .digest_d  (digest.digest_d)
    );

endmodule

// ----- hdl/md5_ctrl.sv -----
// md5_ctrl: sequencer for word intake, 64-round compression, padding and output
// depends on md5_pkg (command and status structs, round and position limits)

module md5_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                word_present,
    input  logic                end_of_message,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  md5_pkg::md5_stat_t  stat,
    output md5_pkg::md5_cmd_t   cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROUND,
        S_FOLD,
        S_PAD,
        S_LEN,
        S_OUT
    } state_t;

    // which compression is running
    typedef enum logic [1:0] {
        PH_BLOCK,
        PH_SPILL,
        PH_FINAL
    } phase_t;

    state_t     state_reg, state_next;
    phase_t     phase_reg, phase_next;
    logic [5:0] round_reg, round_next;
    logic       fin_reg, fin_next;

    always_comb
    begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        round_next    = round_reg;
        fin_next      = fin_reg;
        cmd           = '0;
        cmd.round_idx = round_reg;
        in_ready      = 1'b0;
        out_valid     = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_word = word_present;
                    if (word_present && stat.pos == md5_pkg::POS_LAST)
                    begin
                        cmd.init_work = 1'b1;
                        round_next    = '0;
                        phase_next    = PH_BLOCK;
                        fin_next      = end_of_message;
                        state_next    = S_ROUND;
                    end
                    else if (end_of_message)
                    begin
                        state_next = S_PAD;
                    end
                end
            end
            S_ROUND:
            begin
                cmd.do_round = 1'b1;
                round_next   = round_reg + 6'd1;
                if (round_reg == md5_pkg::ROUND_LAST)
                begin
                    state_next = S_FOLD;
                end
            end
            S_FOLD:
            begin
                cmd.fold = 1'b1;
                case (phase_reg)
                    PH_BLOCK: state_next = fin_reg ? S_PAD : S_IDLE;
                    PH_SPILL: state_next = S_LEN;
                    PH_FINAL: state_next = S_OUT;
                    default:  state_next = S_IDLE;
                endcase
            end
            S_PAD:
            begin
                cmd.pad       = 1'b1;
                cmd.init_work = 1'b1;
                round_next    = '0;
                state_next    = S_ROUND;
                if (stat.pos == md5_pkg::POS_LAST)
                begin
                    // no room for the length, it goes into an extra block
                    phase_next = PH_SPILL;
                end
                else
                begin
                    cmd.write_len = 1'b1;
                    phase_next    = PH_FINAL;
                end
            end
            S_LEN:
            begin
                cmd.clear_blk = 1'b1;
                cmd.write_len = 1'b1;
                cmd.init_work = 1'b1;
                round_next    = '0;
                phase_next    = PH_FINAL;
                state_next    = S_ROUND;
            end
            S_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    cmd.restart = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            phase_reg <= PH_BLOCK;
            round_reg <= '0;
            fin_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            round_reg <= round_next;
            fin_reg   <= fin_next;
        end
    end

endmodule

// ----- hdl/md5_dp.sv -----
// md5_dp: block buffer, word counters, chaining value and one md5 round per cycle
// depends on md5_pkg (command and status structs, initial value, round tables)

module md5_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  md5_pkg::md5_cmd_t   cmd,
    input  logic [63:0]         data_word,
    output md5_pkg::md5_stat_t  stat,
    output logic [31:0]         digest_a,
    output logic [31:0]         digest_b,
    output logic [31:0]         digest_c,
    output logic [31:0]         digest_d
);

    logic [31:0] blk_reg [16];
    logic [31:0] blk_next [16];
    logic [31:0] cv_reg [4];
    logic [31:0] wa_reg, wb_reg, wc_reg, wd_reg;
    logic [2:0]  pos_reg;
    logic [60:0] count_reg;

    logic [3:0]  pos2;
    logic [63:0] bit_len;
    logic [5:0]  ri;
    logic [3:0]  ri4;
    logic [31:0] f_val;
    logic [3:0]  g_idx;
    logic [31:0] sum;
    logic [4:0]  shamt;
    logic [63:0] rot_dbl;
    logic [31:0] new_b;

    assign pos2     = {pos_reg, 1'b0};
    assign bit_len  = {count_reg[57:0], 6'b0};
    assign stat.pos = pos_reg;

    assign digest_a = cv_reg[0];
    assign digest_b = cv_reg[1];
    assign digest_c = cv_reg[2];
    assign digest_d = cv_reg[3];

    // round function
    assign ri  = cmd.round_idx;
    assign ri4 = ri[3:0];

    always_comb
    begin
        case (ri[5:4])
            2'd0:
            begin
                f_val = (wb_reg & wc_reg) | (~wb_reg & wd_reg);
                g_idx = ri4;
            end
            2'd1:
            begin
                f_val = (wd_reg & wb_reg) | (~wd_reg & wc_reg);
                g_idx = (ri4 << 2) + ri4 + 4'd1;
            end
            2'd2:
            begin
                f_val = wb_reg ^ wc_reg ^ wd_reg;
                g_idx = (ri4 << 1) + ri4 + 4'd5;
            end
            default:
            begin
                f_val = wc_reg ^ (wb_reg | ~wd_reg);
                g_idx = (ri4 << 3) - ri4;
            end
        endcase
    end

    assign sum     = wa_reg + f_val + md5_pkg::round_const(ri) + blk_reg[g_idx];
    assign shamt   = md5_pkg::rot_amount({ri[5:4], ri[1:0]});
    assign rot_dbl = {sum, sum} << shamt;
    assign new_b   = wb_reg + rot_dbl[63:32];

    // buffer writes: word load, padding, clear, then length on top
    always_comb
    begin
        for (int k = 0; k < 16; k++)
        begin
            blk_next[k] = blk_reg[k];
            if (cmd.load_word)
            begin
                if (4'(k) == pos2)
                begin
                    blk_next[k] = data_word[31:0];
                end
                else if (4'(k) == (pos2 | 4'd1))
                begin
                    blk_next[k] = data_word[63:32];
                end
            end
            if (cmd.pad)
            begin
                if (4'(k) == pos2)
                begin
                    blk_next[k] = md5_pkg::PAD_WORD;
                end
                else if (4'(k) > pos2)
                begin
                    blk_next[k] = '0;
                end
            end
            if (cmd.clear_blk)
            begin
                blk_next[k] = '0;
            end
        end
        if (cmd.write_len)
        begin
            blk_next[14] = bit_len[31:0];
            blk_next[15] = bit_len[63:32];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 16; k++)
        begin
            blk_reg[k] <= blk_next[k];
        end
        if (cmd.init_work)
        begin
            wa_reg <= cv_reg[0];
            wb_reg <= cv_reg[1];
            wc_reg <= cv_reg[2];
            wd_reg <= cv_reg[3];
        end
        else if (cmd.do_round)
        begin
            wa_reg <= wd_reg;
            wd_reg <= wc_reg;
            wc_reg <= wb_reg;
            wb_reg <= new_b;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cv_reg[0] <= md5_pkg::IV_A;
            cv_reg[1] <= md5_pkg::IV_B;
            cv_reg[2] <= md5_pkg::IV_C;
            cv_reg[3] <= md5_pkg::IV_D;
            pos_reg   <= '0;
            count_reg <= '0;
        end
        else if (cmd.restart)
        begin
            cv_reg[0] <= md5_pkg::IV_A;
            cv_reg[1] <= md5_pkg::IV_B;
            cv_reg[2] <= md5_pkg::IV_C;
            cv_reg[3] <= md5_pkg::IV_D;
            pos_reg   <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (cmd.fold)
            begin
                cv_reg[0] <= cv_reg[0] + wa_reg;
                cv_reg[1] <= cv_reg[1] + wb_reg;
                cv_reg[2] <= cv_reg[2] + wc_reg;
                cv_reg[3] <= cv_reg[3] + wd_reg;
            end
            if (cmd.load_word)
            begin
                pos_reg   <= pos_reg + 3'd1;
                count_reg <= count_reg + 61'd1;
            end
        end
    end

endmodule

// ----- hdl/md5_checker.sv -----
// md5_checker: port-level assertions for md5_digest_engine, attached by bind
// no package dependencies; sees only the top-level channel signals

module md5_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        in_present,
    input logic        in_eom,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] dig_a,
    input logic [31:0] dig_b,
    input logic [31:0] dig_c,
    input logic [31:0] dig_d
);

    // a pending digest stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("digest dropped before transfer");

    // a stalled digest holds its value
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(dig_a) && $stable(dig_b)
                                    && $stable(dig_c) && $stable(dig_d))
        else $error("digest changed while stalled");

    // no new word while a digest waits
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input taken while digest pending");

    // finishing keeps the input closed for at least the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_eom |=> !in_ready)
        else $error("input reopened right after end of message");

    // an empty item leaves the block ready
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !in_present && !in_eom |=> in_ready)
        else $error("empty transfer stalled the input");

endmodule

bind md5_digest_engine md5_checker u_md5_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (msg.valid),
    .in_ready   (msg.ready),
    .in_present (msg.word_present),
    .in_eom     (msg.end_of_message),
    .out_valid  (digest.valid),
    .out_ready  (digest.ready),
    .dig_a      (digest.digest_a),
    .dig_b      (digest.digest_b),
    .dig_c      (digest.digest_c),
    .dig_d      (digest.digest_d)
);
